>>> hw/rtl/bcu_pkg.sv
// Shared types and constants of the barometer compensation unit.
`timescale 1ns / 1ps
package bcu_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_AC_SIGNED   = 3'd0,
        CFG_AC_UNSIGNED = 3'd1,
        CFG_B_PAIR      = 3'd2,
        CFG_M_PAIR      = 3'd3,
        CFG_OVERSAMPLE  = 3'd4
    } t_cfg_idx;

    localparam logic [31:0] C_TEMP_OFFSET  = 32'd4000;
    localparam logic [31:0] C_B4_BIAS      = 32'd32768;
    localparam logic [16:0] C_PRESS_SCALE  = 17'd50000;
    localparam logic [31:0] C_P_SQ_COEF    = 32'd3038;
    localparam logic [31:0] C_P_LIN_COEF   = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_OFFSET     = 32'd3791;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_error;
    } t_result;

    // Side data carried through the temperature divider.
    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic        neg;
        logic        err;
    } t_side_t;

    // Side data carried through the pressure divider.
    typedef struct packed {
        logic [15:0] tenths;
        logic        hi;
        logic        err;
    } t_side_p;

endpackage

>>> hw/rtl/bcu_in_if.sv
// Input channel carrying one raw temperature and pressure reading.
`timescale 1ns / 1ps
interface bcu_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;

    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

>>> hw/rtl/bcu_out_if.sv
// Output channel carrying one compensated result.
`timescale 1ns / 1ps
interface bcu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;

    modport source (output valid, temperature_tenths, pressure_pa, divide_error,
                    input ready);
    modport sink (input valid, temperature_tenths, pressure_pa, divide_error,
                  output ready);
endinterface

>>> hw/rtl/barometer_compensation_unit.sv
// Top level of the barometer compensation unit.
`timescale 1ns / 1ps
// Channel   Direction  Handshake         Payload
// i_in      sink       valid / ready     raw_temperature[15:0], raw_pressure[18:0]
// o_out     source     valid / ready     temperature_tenths[15:0], pressure_pa[31:0],
//                                        divide_error
// i_cfg_*   write      i_cfg_we          i_cfg_idx[2:0], i_cfg_data[47:0]
//
// One item may enter every cycle while the skid register is empty. Each item
// passes 79 pipeline registers (two 32-stage dividers plus 15 arithmetic
// stages) before it reaches the output register. Reset is synchronous and
// active low; it clears all valid bits and loads the calibration defaults.
// When the sink stalls, the next finished item parks in a skid register and
// the whole pipeline holds; the input stays ready as long as that skid
// register is empty.
module barometer_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcu_in_if.sink      i_in,
    bcu_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    import bcu_pkg::*;

    // Calibration registers.
    logic [47:0] r_cal_ac_s;
    logic [47:0] r_cal_ac_u;
    logic [31:0] r_cal_b;
    logic [31:0] r_cal_m;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac_s <= '0;
            r_cal_ac_u <= '0;
            r_cal_b    <= '0;
            r_cal_m    <= '0;
            r_oss      <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AC_SIGNED:   r_cal_ac_s <= i_cfg_data;
                CFG_AC_UNSIGNED: r_cal_ac_u <= i_cfg_data;
                CFG_B_PAIR:      r_cal_b    <= i_cfg_data[31:0];
                CFG_M_PAIR:      r_cal_m    <= i_cfg_data[31:0];
                CFG_OVERSAMPLE:  r_oss      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Signed calibration words widened to 32 bits the way the formula uses them; AC4 to AC6 stay 16 bits.
    logic [31:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0] w_ac4, w_ac5, w_ac6;
    assign w_ac1 = {{16{r_cal_ac_s[47]}}, r_cal_ac_s[47:32]};
    assign w_ac2 = {{16{r_cal_ac_s[31]}}, r_cal_ac_s[31:16]};
    assign w_ac3 = {{16{r_cal_ac_s[15]}}, r_cal_ac_s[15:0]};
    assign w_ac4 = r_cal_ac_u[47:32];
    assign w_ac5 = r_cal_ac_u[31:16];
    assign w_ac6 = r_cal_ac_u[15:0];
    assign w_b1  = {{16{r_cal_b[31]}}, r_cal_b[31:16]};
    assign w_b2  = {{16{r_cal_b[15]}}, r_cal_b[15:0]};
    assign w_mc  = {{16{r_cal_m[31]}}, r_cal_m[31:16]};
    assign w_md  = {{16{r_cal_m[15]}}, r_cal_m[15:0]};

    // The whole pipeline advances together whenever the skid stage is free.
    logic w_en;
    assign i_in.ready = w_en;

    // Stage 1: uncalibrated temperature times AC5.
    logic signed [16:0] w_ut_d;
    logic signed [33:0] w_ut_m;
    logic        r1_vld;
    logic [31:0] r1_x1;
    logic [18:0] r1_up;
    always_comb begin
        w_ut_d = $signed({1'b0, i_in.raw_temperature} - {1'b0, w_ac6});
        w_ut_m = w_ut_d * $signed({1'b0, w_ac5});
    end

    // Stage 2: temperature divisor and numerator.
    logic        r2_vld;
    logic [31:0] r2_x1, r2_den, r2_num;
    logic [18:0] r2_up;

    // Stage 3: magnitudes and sign for the signed division.
    logic        r3_vld;
    logic [31:0] r3_nmag, r3_dmag;
    t_side_t     r3_side;

    // Temperature divider.
    logic        w_d1_vld;
    logic [31:0] w_d1_q;
    t_side_t     w_d1_side;

    // Stages 4 through 6: quotient sign, B5, B6 and the temperature result.
    logic        r4_vld, r5_vld, r6_vld;
    logic [31:0] r4_x2, r4_x1, r5_b5, r6_b6;
    logic [18:0] r4_up, r5_up, r6_up;
    logic        r4_err, r5_err, r6_err;
    logic [15:0] r6_tenths;
    logic [31:0] w_b5r, w_t28;

    // Stages 7 through 12: pressure coefficients.
    logic        r7_vld, r8_vld, r9_vld, r10_vld, r11_vld, r12_vld;
    logic [31:0] r7_sq, r7_x2a, r7_x1c;
    logic [31:0] r8_x1a, r8_x2c, r8_x2a, r8_x1c;
    logic [31:0] r9_x3, r9_x3c;
    logic [31:0] r10_b3, r10_b4p;
    logic [31:0] r11_b4, r11_d;
    logic [31:0] r12_b4, r12_b7;
    logic [18:0] r7_up, r8_up, r9_up, r10_up;
    logic        r7_err, r8_err, r9_err, r10_err, r11_err, r12_err;
    logic [15:0] r7_t, r8_t, r9_t, r10_t, r11_t, r12_t;
    logic [31:0] w_m7a, w_m7b, w_m7c, w_m8a, w_m8b, w_b3s, w_m11, w_m12;
    logic [16:0] w_scale;

    // Pressure divider.
    logic        w_d2_vld;
    logic [31:0] w_d2_q;
    t_side_p     w_d2_side, w_d2_in_side;

    // Stages 13 through 15: final pressure polynomial.
    logic        r13_vld, r14_vld, r15_vld;
    logic [31:0] r13_p, r14_p, r14_x1, r14_x2, r15_x1, r15_x2, r15_p;
    logic        r13_err, r14_err, r15_err;
    logic [15:0] r13_t, r14_t, r15_t;
    logic [31:0] w_s, w_m14a, w_m14b, w_m15, w_sum;
    t_result     w_res;

    always_comb begin
        w_b5r = r5_b5 + 32'd8;
        w_t28 = $signed(w_b5r) >>> 4;
        w_m7a = r6_b6 * r6_b6;
        w_m7b = w_ac2 * r6_b6;
        w_m7c = w_ac3 * r6_b6;
        w_m8a = w_b2 * r7_sq;
        w_m8b = w_b1 * r7_sq;
        w_b3s = ((w_ac1 << 2) + r9_x3) << r_oss;
        w_m11 = {16'd0, w_ac4} * r10_b4p;
        w_scale = C_PRESS_SCALE >> r_oss;
        w_m12 = r11_d * {15'd0, w_scale};
        w_s   = $signed(r13_p) >>> 8;
        w_m14a = w_s * w_s;
        w_m14b = C_P_LIN_COEF * r13_p;
        w_m15 = r14_x1 * C_P_SQ_COEF;
        w_sum = r15_x1 + r15_x2 + C_P_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0; r2_vld  <= 1'b0; r3_vld  <= 1'b0;
            r4_vld  <= 1'b0; r5_vld  <= 1'b0; r6_vld  <= 1'b0;
            r7_vld  <= 1'b0; r8_vld  <= 1'b0; r9_vld  <= 1'b0;
            r10_vld <= 1'b0; r11_vld <= 1'b0; r12_vld <= 1'b0;
            r13_vld <= 1'b0; r14_vld <= 1'b0; r15_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= i_in.valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= w_d1_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
            r13_vld <= w_d2_vld;
            r14_vld <= r13_vld;
            r15_vld <= r14_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x1 <= 32'($signed(w_ut_m[31:0]) >>> 15);
            r1_up <= i_in.raw_pressure;

            r2_x1  <= r1_x1;
            r2_den <= r1_x1 + w_md;
            r2_num <= w_mc << 11;
            r2_up  <= r1_up;

            r3_nmag      <= r2_num[31] ? (32'd0 - r2_num) : r2_num;
            r3_dmag      <= r2_den[31] ? (32'd0 - r2_den) : r2_den;
            r3_side.x1   <= r2_x1;
            r3_side.up   <= r2_up;
            r3_side.neg  <= r2_num[31] ^ r2_den[31];
            r3_side.err  <= (r2_den == 32'd0);

            r4_x2  <= w_d1_side.neg ? (32'd0 - w_d1_q) : w_d1_q;
            r4_x1  <= w_d1_side.x1;
            r4_up  <= w_d1_side.up;
            r4_err <= w_d1_side.err;

            r5_b5  <= r4_x1 + r4_x2;
            r5_up  <= r4_up;
            r5_err <= r4_err;

            r6_b6  <= r5_b5 - C_TEMP_OFFSET;
            r6_up  <= r5_up;
            r6_err <= r5_err;
            if ($signed(w_t28) > 32'sd32767) begin
                r6_tenths <= 16'h7FFF;
            end else if ($signed(w_t28) < -32'sd32768) begin
                r6_tenths <= 16'h8000;
            end else begin
                r6_tenths <= w_t28[15:0];
            end

            r7_sq  <= 32'($signed(w_m7a) >>> 12);
            r7_x2a <= 32'($signed(w_m7b) >>> 11);
            r7_x1c <= 32'($signed(w_m7c) >>> 13);
            r7_up  <= r6_up;
            r7_err <= r6_err;
            r7_t   <= r6_tenths;

            r8_x1a <= 32'($signed(w_m8a) >>> 11);
            r8_x2c <= 32'($signed(w_m8b) >>> 16);
            r8_x2a <= r7_x2a;
            r8_x1c <= r7_x1c;
            r8_up  <= r7_up;
            r8_err <= r7_err;
            r8_t   <= r7_t;

            r9_x3  <= r8_x1a + r8_x2a;
            r9_x3c <= 32'($signed(r8_x1c + r8_x2c + 32'd2) >>> 2);
            r9_up  <= r8_up;
            r9_err <= r8_err;
            r9_t   <= r8_t;

            r10_b3  <= 32'($signed(w_b3s + 32'd2) >>> 2);
            r10_b4p <= r9_x3c + C_B4_BIAS;
            r10_up  <= r9_up;
            r10_err <= r9_err;
            r10_t   <= r9_t;

            r11_b4  <= w_m11 >> 15;
            r11_d   <= {13'd0, r10_up} - r10_b3;
            r11_err <= r10_err;
            r11_t   <= r10_t;

            r12_b4  <= r11_b4;
            r12_b7  <= w_m12;
            r12_err <= r11_err | (r11_b4 == 32'd0);
            r12_t   <= r11_t;

            r13_p   <= w_d2_side.hi ? (w_d2_q << 1) : w_d2_q;
            r13_err <= w_d2_side.err;
            r13_t   <= w_d2_side.tenths;

            r14_x1  <= w_m14a;
            r14_x2  <= 32'($signed(w_m14b) >>> 16);
            r14_p   <= r13_p;
            r14_err <= r13_err;
            r14_t   <= r13_t;

            r15_x1  <= 32'($signed(w_m15) >>> 16);
            r15_x2  <= r14_x2;
            r15_p   <= r14_p;
            r15_err <= r14_err;
            r15_t   <= r14_t;
        end
    end

    bcu_div_pipe #(
        .WIDTH  (32),
        .SIDE_W ($bits(t_side_t))
    ) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_num   (r3_nmag),
        .i_den   (r3_dmag),
        .i_side  (r3_side),
        .o_valid (w_d1_vld),
        .o_quot  (w_d1_q),
        .o_side  (w_d1_side)
    );

    // When B7 has its top bit clear the doubling happens before the divide,
    // otherwise it is applied to the quotient.
    assign w_d2_in_side = '{tenths: r12_t, hi: r12_b7[31], err: r12_err};

    bcu_div_pipe #(
        .WIDTH  (32),
        .SIDE_W ($bits(t_side_p))
    ) u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r12_vld),
        .i_num   (r12_b7[31] ? r12_b7 : (r12_b7 << 1)),
        .i_den   (r12_b4),
        .i_side  (w_d2_in_side),
        .o_valid (w_d2_vld),
        .o_quot  (w_d2_q),
        .o_side  (w_d2_side)
    );

    // A zero divisor anywhere forces both results to zero.
    always_comb begin
        w_res.divide_error = r15_err;
        if (r15_err) begin
            w_res.temperature_tenths = '0;
            w_res.pressure_pa        = '0;
        end else begin
            w_res.temperature_tenths = r15_t;
            w_res.pressure_pa        = r15_p + 32'($signed(w_sum) >>> 4);
        end
    end

    t_result w_out;

    bcu_out_buffer u_out_buffer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r15_vld),
        .i_data  (w_res),
        .o_en    (w_en),
        .o_valid (o_out.valid),
        .o_data  (w_out),
        .i_ready (o_out.ready)
    );

    assign o_out.temperature_tenths = w_out.temperature_tenths;
    assign o_out.pressure_pa        = w_out.pressure_pa;
    assign o_out.divide_error       = w_out.divide_error;

    // An error result always carries zero values.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.divide_error |->
            o_out.pressure_pa == 32'd0 && o_out.temperature_tenths == 16'd0)
        else $error("error result with nonzero values");

    // With the output register empty the skid stage is empty too.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while output is empty");

    // The first cycle after reset shows no result.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");
endmodule

>>> hw/rtl/bcu_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bcu_div_pipe #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [WIDTH-1:0]  i_num,
    input  logic [WIDTH-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_vld  [WIDTH+1];
    logic [WIDTH-1:0]  r_rem  [WIDTH+1];
    logic [WIDTH-1:0]  r_nq   [WIDTH+1];
    logic [WIDTH-1:0]  r_den  [WIDTH+1];
    logic [SIDE_W-1:0] r_side [WIDTH+1];

    assign r_vld[0]  = i_valid;
    assign r_rem[0]  = '0;
    assign r_nq[0]   = i_num;
    assign r_den[0]  = i_den;
    assign r_side[0] = i_side;

    for (genvar g = 0; g < WIDTH; g++) begin : g_stage
        logic [WIDTH:0]   w_trial;
        logic [WIDTH-1:0] n_rem;
        logic [WIDTH-1:0] n_nq;

        always_comb begin
            w_trial = {r_rem[g], r_nq[g][WIDTH-1]};
            n_nq    = {r_nq[g][WIDTH-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den[g]}) begin
                n_rem   = WIDTH'(w_trial - {1'b0, r_den[g]});
                n_nq[0] = 1'b1;
            end else begin
                n_rem   = w_trial[WIDTH-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_rem;
                r_nq[g+1]   <= n_nq;
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[WIDTH];
    assign o_quot  = r_nq[WIDTH];
    assign o_side  = r_side[WIDTH];
endmodule

>>> hw/rtl/bcu_out_buffer.sv
// Output register with a skid stage that decouples the pipeline from the sink.
`timescale 1ns / 1ps
module bcu_out_buffer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bcu_pkg::t_result i_data,
    output logic             o_en,
    output logic             o_valid,
    output bcu_pkg::t_result o_data,
    input  logic             i_ready
);
    import bcu_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take  = r_out_vld & i_ready;
    assign o_en    = ~r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_vld && !w_take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (r_out_vld && !w_take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end
endmodule

>>> verif/bcu_result_checker.sv
// Checker that predicts and compares the compensated results of the unit.
`timescale 1ns / 1ps
module bcu_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcu_in_if           i_in,
    bcu_out_if          i_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_error_count
);
    import bcu_pkg::*;

    logic [47:0] cal_ac_s;
    logic [47:0] cal_ac_u;
    logic [31:0] cal_b;
    logic [31:0] cal_m;
    logic [1:0]  oss;

    t_result expected_results[$];

    function automatic logic [31:0] asr(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx(logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    // Bit-exact integer compensation with 32-bit wrapping intermediates.
    function automatic t_result compensate_reading(logic [15:0] ut16, logic [18:0] up19);
        t_result     r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, pres, tq;
        longint      num, dvs, quo;
        ac1 = sx(cal_ac_s[47:32]);
        ac2 = sx(cal_ac_s[31:16]);
        ac3 = sx(cal_ac_s[15:0]);
        ac4 = {16'd0, cal_ac_u[47:32]};
        ac5 = {16'd0, cal_ac_u[31:16]};
        ac6 = {16'd0, cal_ac_u[15:0]};
        b1  = sx(cal_b[31:16]);
        b2  = sx(cal_b[15:0]);
        mc  = sx(cal_m[31:16]);
        md  = sx(cal_m[15:0]);
        ut  = {16'd0, ut16};
        up  = {13'd0, up19};
        r = '0;
        r.divide_error = 1'b1;

        x1  = asr((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        // Signed divide in 64 bits so the overflow case wraps naturally.
        num = longint'($signed(mc << 11));
        dvs = longint'($signed(den));
        quo = num / dvs;
        x2  = quo[31:0];
        b5  = x1 + x2;

        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr((32'd0 - 32'd7357) * p, 16);
        pres = p + asr(x1 + x2 + 32'd3791, 4);

        tq = asr(b5 + 32'd8, 4);
        if ($signed(tq) > 32767) r.temperature_tenths = 16'sh7FFF;
        else if ($signed(tq) < -32768) r.temperature_tenths = 16'sh8000;
        else r.temperature_tenths = tq[15:0];
        r.pressure_pa = pres;
        r.divide_error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 o_result_count, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_error_count = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cal_ac_s <= '0;
            cal_ac_u <= '0;
            cal_b <= '0;
            cal_m <= '0;
            oss <= 2'd1;
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(
                    compensate_reading(i_in.raw_temperature, i_in.raw_pressure));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result with nothing outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.temperature_tenths !== want.temperature_tenths)
                        report_mismatch("temperature_tenths", i_out.temperature_tenths,
                                        want.temperature_tenths);
                    if (i_out.pressure_pa !== want.pressure_pa)
                        report_mismatch("pressure_pa", i_out.pressure_pa, want.pressure_pa);
                    if (i_out.divide_error !== want.divide_error)
                        report_mismatch("divide_error", i_out.divide_error,
                                        want.divide_error);
                    if (want.divide_error) o_error_count++;
                end
                o_result_count++;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_AC_SIGNED:   cal_ac_s <= i_cfg_data;
                    CFG_AC_UNSIGNED: cal_ac_u <= i_cfg_data;
                    CFG_B_PAIR:      cal_b <= i_cfg_data[31:0];
                    CFG_M_PAIR:      cal_m <= i_cfg_data[31:0];
                    CFG_OVERSAMPLE:  oss <= i_cfg_data[1:0];
                    default:         ;
                endcase
            end
        end
    end

endmodule

>>> verif/barometer_compensation_unit_tb.sv
// Top of the testbench: stimulus, flow control and verdict for the unit.
`timescale 1ns / 1ps
module barometer_compensation_unit_tb;
    import bcu_pkg::*;

    // Slowest legal run: each item may wait out a sender gap and a receiver
    // stall plus the pipeline depth; the limit is several times that.
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [47:0] cfg_data;
    int          fail_count;
    int          pending;
    int          result_count;
    int          error_count;
    int          cycle_count;
    int          items_sent;

    // Flow-control modes shared by the stimulus and the receiver process.
    bit          gaps_on;
    bit          hold_request;

    bcu_in_if  in_ch();
    bcu_out_if out_ch();

    barometer_compensation_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    bcu_result_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_error_count (error_count)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // The run is cut off if the design hangs.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("barometer_compensation_unit_tb: FAIL");
            $finish;
        end
    end

    // Receiver side. It stalls in random bursts while gaps are enabled, and on
    // request holds off for a long counted stretch so the pipeline backs up.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                for (int c = 0; c < 400; c++) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offers one reading and waits until the unit accepts it. Valid is left
    // high so back-to-back items need no second assignment in the same step.
    task automatic send_reading(logic [15:0] ut, logic [18:0] up);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_temperature <= ut;
        in_ch.raw_pressure <= up;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Lets every outstanding result come back before the calibration changes.
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the whole calibration set and the oversampling setting.
    task automatic load_calibration(logic [47:0] ac_s, logic [47:0] ac_u,
                                    logic [31:0] b_pair, logic [31:0] m_pair,
                                    logic [1:0] oss);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_AC_SIGNED;   cfg_data <= ac_s;             @(posedge i_clk);
        cfg_idx <= CFG_AC_UNSIGNED; cfg_data <= ac_u;             @(posedge i_clk);
        cfg_idx <= CFG_B_PAIR;      cfg_data <= {16'd0, b_pair};  @(posedge i_clk);
        cfg_idx <= CFG_M_PAIR;      cfg_data <= {16'd0, m_pair};  @(posedge i_clk);
        cfg_idx <= CFG_OVERSAMPLE;  cfg_data <= {46'd0, oss};     @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Typical factory calibration of a real sensor, so that most readings land
    // in the meaningful range of the formula.
    task automatic load_typical(logic [1:0] oss);
        load_calibration({16'sd408, -16'sd72, -16'sd14383},
                         {16'd32741, 16'd32757, 16'd23153},
                         {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, oss);
    endtask

    // Mostly plausible sensor readings, with a quarter spread over the whole range.
    task automatic send_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0)
                send_reading(16'($urandom), 19'($urandom));
            else
                send_reading(16'($urandom_range(20000, 34000)),
                             19'($urandom_range(20000, 60000)));
        end
    endtask

    initial begin
        items_sent = 0;
        gaps_on = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_AC_SIGNED;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration is all zero, so the temperature divisor is zero.
        send_reading(16'h0000, 19'h00000);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'h5555, 19'h2AAAA);
        drain();

        // Typical calibration: field extremes, and a reading where the first
        // term vanishes.
        load_typical(2'd1);
        send_reading(16'h0000, 19'h00000);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'hFFFF, 19'h00000);
        send_reading(16'h0000, 19'h7FFFF);
        send_reading(16'd23153, 19'd40000);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'hAAAA, 19'h55555);
        drain();
        // The temperature divisor is zero when x1 and MD are both zero.
        load_calibration(48'd0, {16'd100, 16'd32768, 16'd0}, 32'd1, 32'h0001_0000, 2'd0);
        send_reading(16'd0, 19'd1);
        drain();
        // AC4 of zero forces the pressure divisor to zero.
        load_calibration({16'sd408, -16'sd72, -16'sd14383}, {16'd0, 16'd32757, 16'd23153},
                         {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd2);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'hFFFF, 19'h7FFFF);
        drain();
        // Most negative numerator over a divisor of minus one.
        load_calibration(48'd0, 48'd0, 32'd0, {16'h8000, 16'hFFFF}, 2'd3);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        drain();

        // Random phases with idling on both sides and a long receiver hold-off.
        gaps_on = 1'b1;
        load_typical(2'd1);
        send_random(60);
        hold_request = 1'b1;
        send_random(240);
        drain();
        load_typical(2'd0);
        send_random(250);
        drain();
        load_typical(2'd3);
        send_random(250);
        drain();
        load_calibration('1, '1, '1, '1, 2'd3);
        send_random(100);
        drain();
        load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         $urandom, $urandom, 2'($urandom_range(0, 3)));
        send_random(250);
        drain();

        // Final stretch: no idling at all, full rate in and out.
        gaps_on = 1'b0;
        load_typical(2'd2);
        send_random(250);
        drain();
        load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         $urandom, $urandom, 2'd0);
        send_random(230);
        drain();

        $display("covered %0d readings and %0d results, %0d with a zero divisor,",
                 items_sent, result_count, error_count);
        $display("over reset, typical, all-ones and random calibrations at every oversampling");
        if (fail_count == 0 && pending == 0)
            $display("barometer_compensation_unit_tb: PASS");
        else
            $display("barometer_compensation_unit_tb: FAIL");
        $finish;
    end

endmodule
